@@ design/dsdg_pkg.sv @@
`timescale 1ns / 1ps

package dsdg_pkg;

    // widths fixed by the stream and config formats
    localparam int HP_W             = 24;
    localparam int TICK_OUT_W       = 32;
    localparam int S_TDATA_W        = 32;
    localparam int S_TUSER_W        = 3;
    localparam int M_TDATA_W        = 40;
    localparam int CFG_ADDR_W       = 2;
    localparam int CFG_DATA_W       = 1;

    localparam int PERIOD_WIDTH_DEF = 24;
    localparam int TICK_WIDTH_DEF   = 32;

    // register indexes on the config port
    localparam logic [CFG_ADDR_W-1:0] CFG_PAN_DIR_POL  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TILT_DIR_POL = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_OUTPUT_EN    = 2'd2;

    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_SPEED   = 2'd1,
        ACT_STOP    = 2'd2,
        ACT_INVALID = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_STEP,
        OP_LOAD,
        OP_STOP,
        OP_CLEAR
    } t_axis_op;

    typedef struct packed {
        t_axis_op op;
        logic     dir_lvl;   // wanted DIR pin level, polarity already applied
    } t_axis_cmd;

    typedef struct packed {
        logic step;
        logic dir;
        logic wr;
    } t_axis_pins;

endpackage

@@ design/dual_axis_step_dir_generator.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Signals                         Contents (lowest bit first)
// s_axis    in   tvalid tready tdata[31:0]       half_period[23:0] forward[24] zeros
//                tuser[2:0]                      action[1:0] axis[2]
// m_axis    out  tvalid tready tdata[39:0]       pan_step pan_dir tilt_step tilt_dir
//                                                pins_written tick_count[36:5] zeros
// cfg       in   i_cfg_wr_en i_cfg_addr i_cfg_wdata  0 pan pol, 1 tilt pol, 2 output enable
//
// One item per cycle unless m_axis stalls: an input register, then one pass of
// axis logic that updates state and loads the result register. Synchronous
// active-low reset clears valid flags, counters, config and axis state;
// polarities and output enable come out of reset at 1. A stalled m_axis holds
// the result register; s_axis keeps accepting while the input register can move on.

module dual_axis_step_dir_generator #(
    parameter int PERIOD_WIDTH = dsdg_pkg::PERIOD_WIDTH_DEF,
    parameter int TICK_WIDTH   = dsdg_pkg::TICK_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // s_axis tdata: half_period[23:0], forward[24], zero pad
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [dsdg_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // s_axis tuser: action[1:0], axis[2]
    input  logic [dsdg_pkg::S_TUSER_W-1:0]    s_axis_tuser,
    // m_axis tdata: pan_step[0], pan_dir[1], tilt_step[2], tilt_dir[3],
    // pins_written[4], tick_count[36:5], zero pad
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [dsdg_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    input  logic                              i_cfg_wr_en,
    input  logic [dsdg_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [dsdg_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import dsdg_pkg::*;

    // config registers
    logic [1:0] r_dir_pol;
    logic       r_out_en;

    // input register
    logic            r_in_valid;
    t_action         r_in_action;
    logic            r_in_axis;
    logic [HP_W-1:0] r_in_hp;
    logic            r_in_fwd;

    // shared state
    logic [TICK_WIDTH-1:0] r_tick, n_tick;
    logic                  r_running, n_running;

    // result register
    logic                  r_out_valid;
    logic [M_TDATA_W-1:0]  r_out_data;

    logic                    w_advance;
    logic                    w_fire;
    logic [PERIOD_WIDTH-1:0] w_period;
    logic [TICK_OUT_W-1:0]   w_tick_out;
    t_axis_cmd               w_cmd  [2];
    t_axis_pins              w_pins [2];

    // result register frees up when empty or being taken
    assign w_advance     = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_advance;
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_pol <= 2'b11;
            r_out_en  <= 1'b1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_PAN_DIR_POL:  r_dir_pol[0] <= i_cfg_wdata[0];
                CFG_TILT_DIR_POL: r_dir_pol[1] <= i_cfg_wdata[0];
                CFG_OUTPUT_EN:    r_out_en     <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_action <= t_action'(s_axis_tuser[1:0]);
            r_in_axis   <= s_axis_tuser[2];
            r_in_hp     <= s_axis_tdata[HP_W-1:0];
            r_in_fwd    <= s_axis_tdata[HP_W];
        end
    end

    // half period brought to the internal period width
    generate
        if (PERIOD_WIDTH > HP_W) begin : g_hp_ext
            assign w_period = {{(PERIOD_WIDTH-HP_W){1'b0}}, r_in_hp};
        end else begin : g_hp_trunc
            assign w_period = r_in_hp[PERIOD_WIDTH-1:0];
        end
    endgenerate

    // per-axis command for this item
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_cmd[k].dir_lvl = r_dir_pol[k] ? r_in_fwd : ~r_in_fwd;
            case (r_in_action)
                ACT_TICK:    w_cmd[k].op = (r_running && r_out_en) ? OP_STEP : OP_HOLD;
                ACT_SPEED:   w_cmd[k].op = (r_in_axis == 1'(k)) ? OP_LOAD : OP_HOLD;
                ACT_STOP:    w_cmd[k].op = OP_STOP;
                ACT_INVALID: w_cmd[k].op = OP_CLEAR;
                default:     w_cmd[k].op = OP_HOLD;
            endcase
        end
    end

    always_comb begin
        n_tick    = r_tick;
        n_running = r_running;
        case (r_in_action)
            ACT_TICK:    n_tick    = r_tick + 1'b1;
            ACT_SPEED:   n_running = 1'b1;
            ACT_STOP:    n_running = 1'b0;
            ACT_INVALID: n_running = 1'b0;
            default: begin
            end
        endcase
    end

    generate
        for (genvar k = 0; k < 2; k++) begin : g_axis
            dsdg_axis #(
                .PERIOD_WIDTH (PERIOD_WIDTH)
            ) u_axis (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_apply  (w_fire),
                .i_cmd    (w_cmd[k]),
                .i_period (w_period),
                .o_pins   (w_pins[k])
            );
        end
    endgenerate

    // reported tick count is the low 32 bits of the counter
    generate
        if (TICK_WIDTH >= TICK_OUT_W) begin : g_tick_trunc
            assign w_tick_out = n_tick[TICK_OUT_W-1:0];
        end else begin : g_tick_ext
            assign w_tick_out = {{(TICK_OUT_W-TICK_WIDTH){1'b0}}, n_tick};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick    <= '0;
            r_running <= 1'b0;
        end else if (w_fire) begin
            r_tick    <= n_tick;
            r_running <= n_running;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_data <= {3'b000, w_tick_out,
                           w_pins[0].wr | w_pins[1].wr,
                           w_pins[1].dir, w_pins[1].step,
                           w_pins[0].dir, w_pins[0].step};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

@@ design/dsdg_axis.sv @@
`timescale 1ns / 1ps

module dsdg_axis #(
    parameter int PERIOD_WIDTH = dsdg_pkg::PERIOD_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_apply,
    input  dsdg_pkg::t_axis_cmd     i_cmd,
    input  logic [PERIOD_WIDTH-1:0] i_period,
    output dsdg_pkg::t_axis_pins    o_pins
);
    import dsdg_pkg::*;

    logic [PERIOD_WIDTH-1:0] r_period, n_period;
    logic [PERIOD_WIDTH-1:0] r_acc, n_acc;
    logic                    r_step, n_step;
    logic                    r_wanted, n_wanted;
    logic                    r_pending, n_pending;
    logic                    r_level, n_level;
    logic                    w_wr;

    always_comb begin
        logic [PERIOD_WIDTH-1:0] base;
        logic [PERIOD_WIDTH-1:0] inc;
        logic                    step_b;
        n_period  = r_period;
        n_acc     = r_acc;
        n_step    = r_step;
        n_wanted  = r_wanted;
        n_pending = r_pending;
        n_level   = r_level;
        w_wr      = 1'b0;
        base      = r_acc;
        step_b    = r_step;
        inc       = '0;
        case (i_cmd.op)
            OP_STEP: begin
                if (r_period == '0) begin
                    w_wr   = r_step;
                    n_step = 1'b0;
                    n_acc  = '0;
                end else begin
                    // direction change: STEP low and restart the count first
                    if (r_pending) begin
                        base      = '0;
                        step_b    = 1'b0;
                        n_pending = 1'b0;
                        n_level   = r_wanted;
                        w_wr      = 1'b1;
                    end
                    inc = base + 1'b1;
                    if (inc >= r_period) begin
                        n_acc  = inc - r_period;
                        n_step = ~step_b;
                        w_wr   = 1'b1;
                    end else begin
                        n_acc  = inc;
                        n_step = step_b;
                    end
                end
            end
            OP_LOAD: begin
                n_period = i_period;
                if (i_period != '0 && i_cmd.dir_lvl != r_wanted) begin
                    n_wanted  = i_cmd.dir_lvl;
                    n_pending = 1'b1;
                end
            end
            OP_STOP: begin
                n_period  = '0;
                n_acc     = '0;
                n_step    = 1'b0;
                n_wanted  = 1'b0;
                n_pending = 1'b0;
                n_level   = 1'b0;
                w_wr      = 1'b1;
            end
            OP_CLEAR: begin
                n_period = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= '0;
            r_acc     <= '0;
            r_step    <= 1'b0;
            r_wanted  <= 1'b0;
            r_pending <= 1'b0;
            r_level   <= 1'b0;
        end else if (i_apply) begin
            r_period  <= n_period;
            r_acc     <= n_acc;
            r_step    <= n_step;
            r_wanted  <= n_wanted;
            r_pending <= n_pending;
            r_level   <= n_level;
        end
    end

    assign o_pins.step = n_step;
    assign o_pins.dir  = n_level;
    assign o_pins.wr   = w_wr;

endmodule

@@ bench/tb_dual_axis_step_dir_generator.sv @@
`timescale 1ns / 1ps

// Bench for the two-axis STEP/DIR generator. A predictor class follows every
// command transfer on s_axis and queues the pin levels it expects. Each m_axis
// transfer is checked, field by field, against the oldest entry. Config writes
// happen only with nothing in flight.

module tb_dual_axis_step_dir_generator;
    import dsdg_pkg::*;

    localparam int CLK_HALF     = 6;        // 12 ns period
    localparam int CYCLE_LIMIT  = 200000;   // far above the slowest legal run
    localparam int RANDOM_ITEMS = 1800;
    localparam int PHASES       = 6;

    // m_axis tdata[36:0] viewed as a packed struct, pan_step in bit 0
    typedef struct packed {
        logic [TICK_OUT_W-1:0] tick_count;
        logic                  pins_written;
        logic                  tilt_dir;
        logic                  tilt_step;
        logic                  pan_dir;
        logic                  pan_step;
    } t_pin_result;

    // Tracks the pin levels of both axes and holds the results still owed
    class pin_predictor;
        bit                    pan_pol;
        bit                    tilt_pol;
        bit                    out_en;
        logic [TICK_OUT_W-1:0] ticks;
        bit                    running;
        logic [HP_W-1:0]       period [2];
        logic [HP_W-1:0]       accum [2];
        bit                    step_lvl [2];
        bit                    dir_want [2];
        bit                    dir_pend [2];
        bit                    dir_lvl [2];
        t_pin_result           expected_pins [$];
        int                    errors;

        function new();
            pan_pol  = 1'b1;
            tilt_pol = 1'b1;
            out_en   = 1'b1;
            ticks    = '0;
            running  = 1'b0;
            errors   = 0;
            for (int k = 0; k < 2; k++) begin
                period[k]   = '0;
                accum[k]    = '0;
                step_lvl[k] = 1'b0;
                dir_want[k] = 1'b0;
                dir_pend[k] = 1'b0;
                dir_lvl[k]  = 1'b0;
            end
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, bit v);
            case (idx)
                CFG_PAN_DIR_POL:  pan_pol  = v;
                CFG_TILT_DIR_POL: tilt_pol = v;
                CFG_OUTPUT_EN:    out_en   = v;
                default: ;
            endcase
        endfunction

        // One tick of one axis; returns 1 when a pin was written
        function bit advance_axis(int k);
            bit wr;
            wr = 1'b0;
            if (period[k] == '0) begin
                wr          = step_lvl[k];
                step_lvl[k] = 1'b0;
                accum[k]    = '0;
                return wr;
            end
            if (dir_pend[k]) begin
                // direction change: STEP low, fresh count, new DIR level
                step_lvl[k] = 1'b0;
                accum[k]    = '0;
                dir_pend[k] = 1'b0;
                dir_lvl[k]  = dir_want[k];
                wr          = 1'b1;
            end
            accum[k] = accum[k] + 1'b1;
            if (accum[k] >= period[k]) begin
                // single subtraction, even after a shorter period was loaded
                accum[k]    = accum[k] - period[k];
                step_lvl[k] = !step_lvl[k];
                wr          = 1'b1;
            end
            return wr;
        endfunction

        function void note_command(t_action act, bit ax, logic [HP_W-1:0] hp, bit fwd);
            bit          wr;
            bit          wr_pan;
            bit          wr_tilt;
            bit          lvl;
            t_pin_result r;
            wr = 1'b0;
            case (act)
                ACT_TICK: begin
                    ticks = ticks + 1'b1;
                    if (running && out_en) begin
                        wr_pan  = advance_axis(0);
                        wr_tilt = advance_axis(1);
                        wr      = wr_pan | wr_tilt;
                    end
                end
                ACT_SPEED: begin
                    period[ax] = hp;
                    running    = 1'b1;
                    if (hp != '0) begin
                        lvl = (ax ? tilt_pol : pan_pol) ? fwd : !fwd;
                        if (lvl != dir_want[ax]) begin
                            dir_want[ax] = lvl;
                            dir_pend[ax] = 1'b1;
                        end
                    end
                end
                ACT_STOP: begin
                    for (int k = 0; k < 2; k++) begin
                        step_lvl[k] = 1'b0;
                        accum[k]    = '0;
                        period[k]   = '0;
                        dir_pend[k] = 1'b0;
                        dir_want[k] = 1'b0;
                        dir_lvl[k]  = 1'b0;
                    end
                    wr      = 1'b1;
                    running = 1'b0;
                end
                default: begin
                    period[0] = '0;
                    period[1] = '0;
                    running   = 1'b0;
                end
            endcase
            r.pan_step     = step_lvl[0];
            r.pan_dir      = dir_lvl[0];
            r.tilt_step    = step_lvl[1];
            r.tilt_dir     = dir_lvl[1];
            r.pins_written = wr;
            r.tick_count   = ticks;
            expected_pins.push_back(r);
        endfunction

        function void compare_field(string name, longint unsigned exp_v,
                                    longint unsigned got_v);
            if (exp_v !== got_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_pins(logic [M_TDATA_W-1:0] data);
            t_pin_result got;
            t_pin_result want;
            got = data[$bits(t_pin_result)-1:0];
            if (expected_pins.size() == 0) begin
                $error("result transfer with no command outstanding: tdata %h", data);
                errors++;
                return;
            end
            want = expected_pins.pop_front();
            compare_field("pan_step",     want.pan_step,     got.pan_step);
            compare_field("pan_dir",      want.pan_dir,      got.pan_dir);
            compare_field("tilt_step",    want.tilt_step,    got.tilt_step);
            compare_field("tilt_dir",     want.tilt_dir,     got.tilt_dir);
            compare_field("pins_written", want.pins_written, got.pins_written);
            compare_field("tick_count",   want.tick_count,   got.tick_count);
        endfunction

        function int pending();
            return expected_pins.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Block under test and its inputs, all known from time zero
    // ------------------------------------------------------------------
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;  // half_period[23:0], forward[24], zeros
    logic [S_TUSER_W-1:0]  s_axis_tuser  = '0;  // action[1:0], axis[2]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // m_axis tdata: pan_step, pan_dir, tilt_step, tilt_dir, pins_written,
    // tick_count[36:5], zeros
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;

    pin_predictor pins = new();

    int idle_pct  = 0;   // chance per cycle that the sender holds off
    int stall_pct = 0;   // chance per cycle that the receiver stalls
    int sent      = 0;   // command transfers so far
    int cycle_count = 0;

    dual_axis_step_dir_generator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Receiver back-pressure, changed on the falling edge only
    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);

    // Both monitors sample on the rising edge, where the transfer happens.
    // The command is noted before the result check of the same edge; as each item
    // passes the input and result registers, the two never refer to the same item.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            pins.note_command(t_action'(s_axis_tuser[1:0]), s_axis_tuser[2],
                              s_axis_tdata[HP_W-1:0], s_axis_tdata[HP_W]);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            pins.check_pins(m_axis_tdata);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** dual_axis_step_dir_generator: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // One command transfer; random hold-off first, tvalid stays up when none
    task automatic send(t_action act, bit ax, logic [HP_W-1:0] hp, bit fwd);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W-HP_W-1){1'b0}}, fwd, hp};
        s_axis_tuser  <= {ax, act};
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
    endtask

    // Sender goes quiet until every owed result has arrived, plus a margin
    // for the two-stage pipeline
    task automatic wait_results_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pins.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, bit v);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        pins.set_reg(idx, v);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // setting bits: [0] pan polarity, [1] tilt polarity, [2] output enable
    task automatic apply_setting(bit [2:0] s);
        write_reg(CFG_PAN_DIR_POL,  s[0]);
        write_reg(CFG_TILT_DIR_POL, s[1]);
        write_reg(CFG_OUTPUT_EN,    s[2]);
    endtask

    // Mostly short periods so that STEP actually toggles; now and then a
    // zero, a long one or the full 24-bit range
    function automatic logic [HP_W-1:0] rand_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)       return '0;
        else if (r < 70) return HP_W'($urandom_range(1, 6));
        else if (r < 92) return HP_W'($urandom_range(7, 40));
        else if (r < 97) return HP_W'($urandom_range(41, 5000));
        else             return HP_W'($urandom);
    endfunction

    function automatic logic [HP_W-1:0] rand_bits();
        return HP_W'($urandom);
    endfunction

    // Mostly well-formed motion: load one or both axes, then a run of ticks.
    // The rest is stops, invalid commands and fully random noise.
    task automatic random_traffic(int target);
        int r;
        int n;
        while (sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                send(ACT_SPEED, $urandom_range(0, 1), rand_period(), $urandom_range(0, 1));
                if ($urandom_range(0, 1))
                    send(ACT_SPEED, $urandom_range(0, 1), rand_period(),
                         $urandom_range(0, 1));
                n = $urandom_range(3, 24);
                repeat (n)
                    send(ACT_TICK, $urandom_range(0, 1), rand_bits(), $urandom_range(0, 1));
            end else if (r < 78) begin
                send(ACT_STOP, $urandom_range(0, 1), rand_bits(), $urandom_range(0, 1));
            end else if (r < 84) begin
                send(ACT_INVALID, $urandom_range(0, 1), rand_bits(), $urandom_range(0, 1));
            end else begin
                send(t_action'($urandom_range(0, 3)), $urandom_range(0, 1), rand_bits(),
                     $urandom_range(0, 1));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        apply_setting(3'b111);

        // directed: ignored fields at extremes on a tick while stopped
        send(ACT_TICK,  1'b1, 24'hFFFFFF, 1'b1);
        // first load sets a pending DIR change, taken on the next tick
        send(ACT_SPEED, 1'b0, 24'd1, 1'b1);
        send(ACT_TICK,  1'b0, 24'd0, 1'b0);
        send(ACT_TICK,  1'b0, 24'd0, 1'b0);
        // reversal: STEP dropped, count restarted, DIR flipped
        send(ACT_SPEED, 1'b0, 24'd1, 1'b0);
        send(ACT_TICK,  1'b0, 24'd0, 1'b0);
        // longest period, same direction as recorded
        send(ACT_SPEED, 1'b1, 24'hFFFFFF, 1'b0);
        send(ACT_TICK,  1'b0, 24'd0, 1'b0);
        send(ACT_SPEED, 1'b1, 24'd2, 1'b1);
        send(ACT_TICK,  1'b0, 24'd0, 1'b0);
        send(ACT_TICK,  1'b0, 24'd0, 1'b0);
        send(ACT_TICK,  1'b0, 24'd0, 1'b0);
        // longer period, then a shorter one loaded while the accumulator is above it
        send(ACT_SPEED, 1'b0, 24'd5, 1'b0);
        send(ACT_TICK,  1'b0, 24'd0, 1'b0);
        send(ACT_TICK,  1'b0, 24'd0, 1'b0);
        send(ACT_TICK,  1'b0, 24'd0, 1'b0);
        send(ACT_SPEED, 1'b0, 24'd1, 1'b0);
        send(ACT_TICK,  1'b0, 24'd0, 1'b0);
        // zero period parks the axis and forces STEP low
        send(ACT_SPEED, 1'b1, 24'd0, 1'b0);
        send(ACT_TICK,  1'b0, 24'd0, 1'b0);
        send(ACT_INVALID, 1'b1, 24'h5A5A5A, 1'b1);
        send(ACT_TICK,  1'b0, 24'd0, 1'b0);
        send(ACT_SPEED, 1'b0, 24'd3, 1'b1);
        send(ACT_STOP,  1'b1, 24'hFFFFFF, 1'b1);
        send(ACT_TICK,  1'b0, 24'd0, 1'b0);
        wait_results_drained();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 66; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 66; end
                default: begin idle_pct = 25; stall_pct = 25; end
            endcase
            // polarities both ways, output enable off for two phases
            case (phase)
                0: apply_setting(3'b110);
                1: apply_setting(3'b011);
                2: apply_setting(3'b100);
                3: apply_setting(3'b101);
                4: apply_setting(3'b000);
                default: apply_setting(3'b111);
            endcase
            random_traffic(sent + RANDOM_ITEMS / PHASES);
            wait_results_drained();
        end

        if (pins.errors == 0)
            $display("** dual_axis_step_dir_generator: PASSED **");
        else
            $display("** dual_axis_step_dir_generator: FAILED **");
        $finish;
    end

endmodule
